FILE: hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants for the connection state table.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam logic [31:0] MAX_AGE_RST = 32'd300;

    localparam logic [1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [1:0] KIND_REFRESH = 2'd1;
    localparam logic [1:0] KIND_ADD     = 2'd2;
    localparam logic [1:0] KIND_SWEEP   = 2'd3;

    localparam logic [2:0] ST_HIT   = 3'd0;
    localparam logic [2:0] ST_ADDED = 3'd1;
    localparam logic [2:0] ST_MISS  = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;
    localparam logic [2:0] ST_SWEEP = 3'd5;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  V6_MASK = 8'hf0;
    localparam logic [7:0]  V6_VER  = 8'h60;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic scan_start;
        logic scan_step;
        logic decide;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic sweep;
        logic scan_done;
    } stat_t;

endpackage

FILE: hw/rtl/cst_if.sv
// ----------------------------------------------------------------------------
// cst_in_if / cst_out_if
// Valid/ready channels for packet words and result words.
// ----------------------------------------------------------------------------
interface cst_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        direction;
    logic [15:0] ethertype;
    logic [15:0] frame_len;
    logic [7:0]  version_ihl;
    logic [7:0]  protocol;
    logic [63:0] src_hi;
    logic [63:0] src_lo;
    logic [63:0] dst_hi;
    logic [63:0] dst_lo;
    logic [47:0] l4_head;
    logic [31:0] now;
    modport source (output valid, kind, direction, ethertype, frame_len, version_ihl,
                    protocol, src_hi, src_lo, dst_hi, dst_lo, l4_head, now,
                    input ready);
    modport sink (input valid, kind, direction, ethertype, frame_len, version_ihl,
                  protocol, src_hi, src_lo, dst_hi, dst_lo, l4_head, now,
                  output ready);
endinterface

interface cst_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] index;
    logic [6:0] in_use;
    logic [6:0] removed;
    modport source (output valid, status, index, in_use, removed, input ready);
    modport sink (input valid, status, index, in_use, removed, output ready);
endinterface

FILE: hw/rtl/cst_ctrl.sv
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: load, check, scan entries, decide, present result.
// ----------------------------------------------------------------------------
module cst_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  cst_pkg::stat_t stat,
    output cst_pkg::cmd_t  cmd
);

    cst_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cst_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cst_pkg::S_IDLE:   if (in_valid) state_next = cst_pkg::S_CHECK;
            cst_pkg::S_CHECK:
                if (stat.bad && !stat.sweep) state_next = cst_pkg::S_OUT;
                else state_next = cst_pkg::S_SCAN;
            cst_pkg::S_SCAN:   if (stat.scan_done) state_next = cst_pkg::S_DECIDE;
            cst_pkg::S_DECIDE: state_next = cst_pkg::S_OUT;
            cst_pkg::S_OUT:    if (out_ready) state_next = cst_pkg::S_IDLE;
            default:           state_next = cst_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            cst_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cst_pkg::S_CHECK:
            begin
                cmd.check = 1'b1;
                cmd.scan_start = 1'b1;
            end
            cst_pkg::S_SCAN:   cmd.scan_step = 1'b1;
            cst_pkg::S_DECIDE: cmd.decide = 1'b1;
            cst_pkg::S_OUT:    out_valid = 1'b1;
            default:           cmd = '0;
        endcase
    end

endmodule

FILE: hw/rtl/cst_dp.sv
// ----------------------------------------------------------------------------
// cst_dp
// Flow store, entry compare, free-slot search, sweep and result register.
// ----------------------------------------------------------------------------
module cst_dp #(
    parameter int ENTRIES = cst_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cst_pkg::cmd_t  cmd,
    output cst_pkg::stat_t stat,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_data,
    input  logic [1:0]     kind,
    input  logic           direction,
    input  logic [15:0]    ethertype,
    input  logic [15:0]    frame_len,
    input  logic [7:0]     version_ihl,
    input  logic [7:0]     protocol,
    input  logic [63:0]    src_hi,
    input  logic [63:0]    src_lo,
    input  logic [63:0]    dst_hi,
    input  logic [63:0]    dst_lo,
    input  logic [47:0]    l4_head,
    input  logic [31:0]    now,
    output logic [2:0]     status,
    output logic [5:0]     index,
    output logic [6:0]     in_use,
    output logic [6:0]     removed
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef struct packed {
        logic [7:0]  proto;
        logic [63:0] shi;
        logic [63:0] slo;
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [15:0] sp;
        logic [15:0] dp;
    } flow_t;

    flow_t       mem_flow [ENTRIES];
    logic [31:0] mem_stamp [ENTRIES];

    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] v6_reg;
    logic [CW-1:0]      count_reg;
    logic [31:0]        max_age_reg;

    logic [1:0]  kind_reg;
    logic        out_dir_reg;
    logic [15:0] etype_reg;
    logic [15:0] flen_reg;
    logic [7:0]  vihl_reg;
    logic [7:0]  proto_in_reg;
    logic [63:0] shi_reg, slo_reg, dhi_reg, dlo_reg;
    logic [47:0] l4_reg;
    logic [31:0] now_reg;

    logic          v6_pkt_reg;
    logic          add_ok_reg;
    logic          icmp_bad_reg;
    logic          hit_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          free_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW:0]   scan_reg;
    logic [CW-1:0] rem_reg;
    logic          rd_ok_reg;
    logic [IW-1:0] rd_idx_reg;
    flow_t         rd_flow_reg;
    logic [31:0]   rd_stamp_reg;

    logic [2:0] status_reg;
    logic [5:0] index_reg;
    logic [6:0] removed_reg;

    logic [16:0] l3len;
    logic [6:0]  hlen;
    logic        chk_bad;
    logic        chk_add;
    logic        is_udp_tcp;
    logic [15:0] p0, p1, ident;
    logic [7:0]  itype, icode;
    logic        amatch, pmatch, icmp_ok;
    logic        stale;
    logic [IW-1:0] rd_addr;
    logic [63:0] ashi, aslo, adhi, adlo;

    assign l3len = {1'b0, flen_reg} - 17'd14;
    assign hlen = {1'b0, vihl_reg[3:0], 2'b00};
    assign is_udp_tcp = (proto_in_reg == cst_pkg::PROTO_UDP) ||
                        (proto_in_reg == cst_pkg::PROTO_TCP);
    assign p0 = l4_reg[47:32];
    assign p1 = l4_reg[31:16];
    assign ident = l4_reg[15:0];
    assign itype = l4_reg[47:40];
    assign icode = l4_reg[39:32];
    assign ashi = (etype_reg == cst_pkg::ETH_IPV4) ? 64'd0 : shi_reg;
    assign adhi = (etype_reg == cst_pkg::ETH_IPV4) ? 64'd0 : dhi_reg;
    assign aslo = (etype_reg == cst_pkg::ETH_IPV4) ? {32'd0, slo_reg[31:0]} : slo_reg;
    assign adlo = (etype_reg == cst_pkg::ETH_IPV4) ? {32'd0, dlo_reg[31:0]} : dlo_reg;

    always_comb
    begin
        chk_bad = 1'b1;
        chk_add = 1'b0;
        if (flen_reg >= 16'd14) begin
            if (etype_reg == cst_pkg::ETH_IPV4) begin
                chk_bad = (l3len < 17'd20) || (vihl_reg[7:4] != 4'd4) ||
                          (hlen < 7'd20) || (l3len < {10'd0, hlen} + 17'd4);
                chk_add = (l3len >= {10'd0, hlen} + 17'd8) && (is_udp_tcp ||
                          (proto_in_reg == cst_pkg::PROTO_ICMP && itype == 8'd8 &&
                           icode == 8'd0));
            end else if (etype_reg == cst_pkg::ETH_IPV6) begin
                chk_bad = (l3len < 17'd44) ||
                          ((vihl_reg & cst_pkg::V6_MASK) != cst_pkg::V6_VER);
                chk_add = (l3len >= 17'd48) && is_udp_tcp;
            end
        end
    end

    // entry read pipeline: the entry at the scan address is registered before compare
    assign rd_addr = scan_reg[IW-1:0];

    always_comb
    begin
        if (out_dir_reg)
            amatch = aslo == rd_flow_reg.slo && ashi == rd_flow_reg.shi &&
                     adlo == rd_flow_reg.dlo && adhi == rd_flow_reg.dhi;
        else
            amatch = adlo == rd_flow_reg.slo && adhi == rd_flow_reg.shi &&
                     aslo == rd_flow_reg.dlo && ashi == rd_flow_reg.dhi;
        amatch = amatch && valid_reg[rd_idx_reg] && v6_reg[rd_idx_reg] == v6_pkt_reg &&
                 rd_flow_reg.proto == proto_in_reg;
        pmatch = out_dir_reg ? (p0 == rd_flow_reg.sp && p1 == rd_flow_reg.dp)
                             : (p1 == rd_flow_reg.sp && p0 == rd_flow_reg.dp);
        icmp_ok = proto_in_reg == cst_pkg::PROTO_ICMP && !v6_pkt_reg &&
                  itype == (out_dir_reg ? 8'd8 : 8'd0) && icode == 8'd0;
        stale = valid_reg[rd_idx_reg] &&
                ({1'b0, rd_stamp_reg} + {1'b0, max_age_reg} < {1'b0, now_reg});
    end

    always_ff @(posedge clk)
    begin
        rd_flow_reg <= mem_flow[rd_addr];
        rd_stamp_reg <= mem_stamp[rd_addr];
        rd_idx_reg <= rd_addr;
        if (cmd.decide && kind_reg == cst_pkg::KIND_ADD && !hit_reg && !icmp_bad_reg &&
            free_reg && add_ok_reg) begin
            mem_flow[free_idx_reg] <= '{proto: proto_in_reg,
                shi: ashi, slo: aslo, dhi: adhi, dlo: adlo,
                sp: (proto_in_reg == cst_pkg::PROTO_ICMP) ? 16'd0 : p0,
                dp: (proto_in_reg == cst_pkg::PROTO_ICMP) ? ident : p1};
            mem_stamp[free_idx_reg] <= now_reg;
        end else if (cmd.decide && hit_reg && kind_reg != cst_pkg::KIND_LOOKUP &&
                     !icmp_bad_reg)
            mem_stamp[hit_idx_reg] <= now_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            kind_reg <= kind;
            out_dir_reg <= direction;
            etype_reg <= ethertype;
            flen_reg <= frame_len;
            vihl_reg <= version_ihl;
            proto_in_reg <= protocol;
            shi_reg <= src_hi;
            slo_reg <= src_lo;
            dhi_reg <= dst_hi;
            dlo_reg <= dst_lo;
            l4_reg <= l4_head;
            now_reg <= now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            v6_reg <= '0;
            count_reg <= '0;
            max_age_reg <= cst_pkg::MAX_AGE_RST;
            add_ok_reg <= 1'b0;
            v6_pkt_reg <= 1'b0;
            icmp_bad_reg <= 1'b0;
            hit_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_reg <= 1'b0;
            free_idx_reg <= '0;
            scan_reg <= '0;
            rem_reg <= '0;
            rd_ok_reg <= 1'b0;
            status_reg <= cst_pkg::ST_HIT;
            index_reg <= '0;
            removed_reg <= '0;
        end else begin
            if (cfg_we) max_age_reg <= cfg_data;
            if (cmd.check) begin
                add_ok_reg <= chk_add;
                v6_pkt_reg <= etype_reg == cst_pkg::ETH_IPV6;
            end
            if (cmd.scan_start) begin
                scan_reg <= '0;
                rd_ok_reg <= 1'b0;
                hit_reg <= 1'b0;
                hit_idx_reg <= '0;
                icmp_bad_reg <= 1'b0;
                free_reg <= 1'b0;
                free_idx_reg <= '0;
                rem_reg <= '0;
            end
            if (cmd.scan_step) begin
                if (scan_reg < ENTRIES[IW:0]) scan_reg <= scan_reg + 1'b1;
                rd_ok_reg <= scan_reg < ENTRIES[IW:0];
                if (rd_ok_reg) begin
                    if (kind_reg == cst_pkg::KIND_SWEEP) begin
                        if (stale) begin
                            valid_reg[rd_idx_reg] <= 1'b0;
                            rem_reg <= rem_reg + 1'b1;
                        end
                    end else begin
                        if (!valid_reg[rd_idx_reg] && !free_reg) begin
                            free_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (amatch && !hit_reg && !icmp_bad_reg) begin
                            if (is_udp_tcp) begin
                                if (pmatch) begin
                                    hit_reg <= 1'b1;
                                    hit_idx_reg <= rd_idx_reg;
                                end
                            end else if (icmp_ok) begin
                                if (ident == rd_flow_reg.dp) begin
                                    hit_reg <= 1'b1;
                                    hit_idx_reg <= rd_idx_reg;
                                end
                            end else
                                icmp_bad_reg <= 1'b1;
                        end
                    end
                end
            end
            if (cmd.check && chk_bad && kind_reg != cst_pkg::KIND_SWEEP) begin
                status_reg <= cst_pkg::ST_BAD;
                index_reg <= '0;
                removed_reg <= '0;
            end
            if (cmd.decide) begin
                index_reg <= '0;
                removed_reg <= '0;
                if (kind_reg == cst_pkg::KIND_SWEEP) begin
                    status_reg <= cst_pkg::ST_SWEEP;
                    removed_reg <= 7'(rem_reg);
                    count_reg <= count_reg - rem_reg;
                end else if (icmp_bad_reg)
                    status_reg <= cst_pkg::ST_BAD;
                else if (hit_reg) begin
                    status_reg <= cst_pkg::ST_HIT;
                    index_reg <= 6'(hit_idx_reg);
                end else if (kind_reg != cst_pkg::KIND_ADD)
                    status_reg <= cst_pkg::ST_MISS;
                else if (!free_reg)
                    status_reg <= cst_pkg::ST_FULL;
                else if (!add_ok_reg)
                    status_reg <= cst_pkg::ST_BAD;
                else begin
                    status_reg <= cst_pkg::ST_ADDED;
                    index_reg <= 6'(free_idx_reg);
                    valid_reg[free_idx_reg] <= 1'b1;
                    v6_reg[free_idx_reg] <= v6_pkt_reg;
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    assign stat.bad = chk_bad;
    assign stat.sweep = kind_reg == cst_pkg::KIND_SWEEP;
    assign stat.scan_done = rd_ok_reg && scan_reg == ENTRIES[IW:0] &&
                            rd_idx_reg == IW'(ENTRIES - 1);
    assign status = status_reg;
    assign index = index_reg;
    assign in_use = 7'(count_reg);
    assign removed = removed_reg;

endmodule

FILE: hw/rtl/connection_state_table_core.sv
// ----------------------------------------------------------------------------
// connection_state_table_core
// Five-tuple flow table with lookup, refresh, add and age sweep.
// ----------------------------------------------------------------------------
// Each word's result follows the scan that reads one table entry per cycle
// from the flow memory; malformed packets that are not sweeps skip the scan
// and go from the check straight to the result. One word is in flight at
// a time; the result holds until taken. The table is empty after reset.
module connection_state_table_core #(
    parameter int ENTRIES = cst_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_data,
    cst_in_if.sink      in_ch,
    cst_out_if.source   out_ch
);

    cst_pkg::cmd_t  cmd;
    cst_pkg::stat_t stat;

    cst_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .stat(stat), .cmd(cmd)
    );

    cst_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .kind(in_ch.kind), .direction(in_ch.direction), .ethertype(in_ch.ethertype),
        .frame_len(in_ch.frame_len), .version_ihl(in_ch.version_ihl),
        .protocol(in_ch.protocol), .src_hi(in_ch.src_hi), .src_lo(in_ch.src_lo),
        .dst_hi(in_ch.dst_hi), .dst_lo(in_ch.dst_lo), .l4_head(in_ch.l4_head),
        .now(in_ch.now),
        .status(out_ch.status), .index(out_ch.index), .in_use(out_ch.in_use),
        .removed(out_ch.removed)
    );

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("accept while result pending");
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != cst_pkg::ST_HIT &&
        out_ch.status != cst_pkg::ST_ADDED |-> out_ch.index == 6'd0)
        else $error("index not zero");
    a_rem_pkt: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.status != cst_pkg::ST_SWEEP |-> out_ch.removed == 7'd0)
        else $error("removed on packet");

endmodule
